// File: rtl/mhtc_pkg.sv
`timescale 1ns / 1ps
package mhtc_pkg;

  localparam int BUCKETS = 1024;
  localparam int WAYS    = 16;
  localparam int HASHES  = 4;
  localparam int QDEPTH  = 2;

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int HSH_W = (HASHES > 1) ? $clog2(HASHES) : 1;
  localparam int QP_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W  = $clog2(QDEPTH + 1);

  localparam logic [31:0] HASH_MULT [4] = '{
    32'd1072573589, 32'd3465827623, 32'd2848548977, 32'd748191707
  };

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef logic [BKT_W-1:0] bkt_t;

  typedef struct packed {
    logic [31:0] tm;
    logic [31:0] value;
    logic [31:0] key;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic                    nop;
    logic                    cmd;
    logic [31:0]             key;
    logic [31:0]             value;
    logic [31:0]             now;
    bkt_t [HASHES-1:0]       bkt;
  } item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_COMP,
    B_WRITE,
    B_RESP
  } back_state_t;

endpackage

// File: rtl/mhtc_front.sv
`timescale 1ns / 1ps
module mhtc_front import mhtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // key[31:0], value[63:32], now[95:64]
  input  logic        s_tuser,   // cmd
  input  logic        init_done,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_ready
);

  front_state_t state, state_next;
  item_t             item;
  logic [HSH_W-1:0]  hcnt;
  logic [31:0]       prod;
  logic              accept;

  // one multiply per hash, result registered into the bucket list
  assign prod   = 32'(item.key * HASH_MULT[hcnt]);
  assign accept = s_tvalid && s_tready;
  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    q_valid    = 1'b0;
    case (state)
      F_IDLE: begin
        s_tready = init_done;
        if (s_tvalid && init_done) begin
          state_next = (s_tdata[31:0] == 32'd0) ? F_PUSH : F_HASH;
        end
      end
      F_HASH: begin
        if (hcnt == HSH_W'(HASHES - 1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.nop   <= (s_tdata[31:0] == 32'd0);
      item.cmd   <= s_tuser;
      item.key   <= s_tdata[31:0];
      item.value <= s_tdata[63:32];
      item.now   <= s_tdata[95:64];
      item.bkt   <= '0;
      hcnt       <= '0;
    end else if (state == F_HASH) begin
      item.bkt[hcnt] <= BKT_W'(prod % 32'(BUCKETS));
      hcnt           <= hcnt + 1'b1;
    end
  end

endmodule

// File: rtl/mhtc_queue.sv
`timescale 1ns / 1ps
module mhtc_queue import mhtc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t            buf_q [QDEPTH];
  logic [QP_W-1:0]  wptr;
  logic [QP_W-1:0]  rptr;
  logic [QC_W-1:0]  count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != QC_W'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_item  = buf_q[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QP_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QP_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wptr] <= in_item;
    end
  end

endmodule

// File: rtl/mhtc_back.sv
`timescale 1ns / 1ps
module mhtc_back import mhtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  input  logic [31:0] timeout_ticks,
  output logic        init_done,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata  // hit[0], found_value[32:1], expired[33],
                               // stored[34], filled_empty[35]
);

  localparam int LV = WAY_W;
  localparam int WP = 1 << LV;

  back_state_t state, state_next;

  item_t             cur;
  logic [HSH_W-1:0]  h;
  logic [31:0]       best_time;
  bkt_t              best_row;
  logic [WAY_W-1:0]  best_way;
  logic              have;
  bkt_t              wrow;
  logic [WAY_W-1:0]  wway;
  slot_t             wdata;
  bkt_t              clr_row;
  logic              r_hit, r_exp, r_stored, r_fe;
  logic [31:0]       r_val;
  logic              o_hit, o_exp, o_stored, o_fe;
  logic [31:0]       o_val;

  // memory port
  logic [WAYS-1:0]   we;
  bkt_t              mem_row;
  slot_t             mem_data;
  bkt_t              raddr;
  slot_t             rdata [WAYS];

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    slot_t mem [BUCKETS];
    always_ff @(posedge clk) begin
      if (we[w]) begin
        mem[mem_row] <= mem_data;
      end
      rdata[w] <= mem[raddr];
    end
  end

  // row compare: first matching way and first oldest way
  logic [WAYS-1:0]   match;
  logic              mfound;
  logic [WAY_W-1:0]  midx;
  slot_t             mslot;
  logic [31:0]       tt [LV+1][WP];
  logic [WAY_W-1:0]  ti [LV+1][WP];
  logic [31:0]       rmin;
  logic [WAY_W-1:0]  rmin_idx;

  always_comb begin
    mfound = 1'b0;
    midx   = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (rdata[w].key == cur.key);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        mfound = 1'b1;
        midx   = WAY_W'(w);
      end
    end
  end

  assign mslot = rdata[midx];

  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int i = 0; i < WP; i++) begin
        tt[l][i] = '1;
        ti[l][i] = '0;
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      tt[0][i] = rdata[i].tm;
      ti[0][i] = WAY_W'(i);
    end
    // ties keep the lower way
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < WP / 2; i++) begin
        if (i < (WP >> (l + 1))) begin
          if (tt[l][2*i+1] < tt[l][2*i]) begin
            tt[l+1][i] = tt[l][2*i+1];
            ti[l+1][i] = ti[l][2*i+1];
          end else begin
            tt[l+1][i] = tt[l][2*i];
            ti[l+1][i] = ti[l][2*i];
          end
        end
      end
    end
    rmin     = tt[LV][0];
    rmin_idx = ti[LV][0];
  end

  logic              ins;
  logic              exp_hit;
  logic              upd;
  logic              fin_have;
  logic [31:0]       fin_time;
  bkt_t              fin_row;
  logic [WAY_W-1:0]  fin_way;
  logic              last;
  logic              out_free;

  assign ins      = (cur.cmd == CMD_INSERT);
  assign exp_hit  = ({1'b0, mslot.tm} + {1'b0, timeout_ticks}) < {1'b0, cur.now};
  assign upd      = !mfound && (rmin < best_time);
  assign fin_have = have || upd;
  assign fin_time = upd ? rmin : best_time;
  assign fin_row  = upd ? cur.bkt[h] : best_row;
  assign fin_way  = upd ? rmin_idx : best_way;
  assign last     = (h == HSH_W'(HASHES - 1));
  assign out_free = !m_tvalid || m_tready;
  assign raddr    = cur.bkt[h];
  assign init_done = (state != B_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    we         = '0;
    mem_row    = wrow;
    mem_data   = wdata;
    case (state)
      B_CLEAR: begin
        we       = '1;
        mem_row  = clr_row;
        mem_data = '0;
        if (clr_row == BKT_W'(BUCKETS - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          state_next = q_item.nop ? B_RESP : B_READ;
        end
      end
      B_READ: state_next = B_COMP;
      B_COMP: begin
        if (mfound) begin
          state_next = (ins || exp_hit) ? B_WRITE : B_RESP;
        end else if (last) begin
          state_next = (ins && fin_have) ? B_WRITE : B_RESP;
        end else begin
          state_next = B_READ;
        end
      end
      B_WRITE: begin
        we[wway]   = 1'b1;
        state_next = B_RESP;
      end
      B_RESP: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (state == B_CLEAR) begin
      clr_row <= clr_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          cur       <= q_item;
          h         <= '0;
          best_time <= q_item.now;
          have      <= 1'b0;
          r_hit     <= 1'b0;
          r_exp     <= 1'b0;
          r_stored  <= 1'b0;
          r_fe      <= 1'b0;
          r_val     <= '0;
        end
      end
      B_COMP: begin
        if (mfound) begin
          wrow <= cur.bkt[h];
          wway <= midx;
          if (ins) begin
            wdata    <= '{tm: cur.now, value: cur.value, key: cur.key};
            r_stored <= 1'b1;
          end else if (exp_hit) begin
            wdata <= '0;
            r_exp <= 1'b1;
          end else begin
            r_hit <= 1'b1;
            r_val <= mslot.value;
          end
        end else begin
          best_time <= fin_time;
          best_row  <= fin_row;
          best_way  <= fin_way;
          have      <= fin_have;
          h         <= h + 1'b1;
          if (last && ins && fin_have) begin
            wrow     <= fin_row;
            wway     <= fin_way;
            wdata    <= '{tm: cur.now, value: cur.value, key: cur.key};
            r_stored <= 1'b1;
            r_fe     <= (fin_time == 32'd0);
          end
        end
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == B_RESP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_RESP && out_free) begin
      o_hit    <= r_hit;
      o_val    <= r_val;
      o_exp    <= r_exp;
      o_stored <= r_stored;
      o_fe     <= r_fe;
    end
  end

  assign m_tdata = {4'b0, o_fe, o_stored, o_exp, o_val, o_hit};

  a_write_onehot: assert property (@(posedge clk) disable iff (rst)
    state == B_WRITE |-> $onehot(we))
    else $error("write-back must hit exactly one way");

  a_hit_not_exp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(o_hit && (o_exp || o_stored)))
    else $error("hit reported together with expired or stored");

  a_val_only_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !o_hit |-> o_val == 32'd0)
    else $error("found_value nonzero without hit");

  a_fe_stored: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_fe |-> o_stored)
    else $error("filled_empty without stored");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    state == B_CLEAR |-> !q_ready)
    else $error("queue popped during clear pass");

endmodule

// File: rtl/multi_hash_timed_cache.sv
`timescale 1ns / 1ps
// Key/value cache of BUCKETS x WAYS slots (1024 x 16); each key probes HASHES (4)
// buckets chosen by multiplicative hashes. After reset a clearing pass writes one
// bucket row per cycle; no word is accepted until it ends. A word is then
// registered on entry, hashed once per bucket in the front end (one shared 32x32
// multiplier; key 0 skips hashing), pushed into the two-entry queue, and in the
// back end popped, then each bucket scanned is read and given a 16-way compare,
// with one write-back on a store, refresh or expiry, before the result goes to
// the output register. The front end overlaps with the back end through the queue.
// Register 0 (byte address 0) is timeout_ticks; write it only while the cache is
// idle.
module multi_hash_timed_cache import mhtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // key[31:0], value[63:32], now[95:64]
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // hit[0], found_value[32:1], expired[33],
                                 // stored[34], filled_empty[35]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] timeout_ticks;
  logic        init_done;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  item_t       fq_item, bq_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? timeout_ticks : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      timeout_ticks <= pwdata;
    end
  end

  mhtc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .init_done (init_done),
    .q_valid   (fq_valid),
    .q_item    (fq_item),
    .q_ready   (fq_ready)
  );

  mhtc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_item  (bq_item)
  );

  mhtc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (bq_valid),
    .q_ready       (bq_ready),
    .q_item        (bq_item),
    .timeout_ticks (timeout_ticks),
    .init_done     (init_done),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

endmodule
